[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL; defining ASSERT_OFF empties them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: property violated");
// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[sv/tls_pkg.sv]
// ----------------------------------------------------------------------------
// tls_pkg
// Widths, beat types, lane control and lane pairing for the tetrahedron
// stiffness block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tls_pkg;

    localparam int NODES    = 4;
    localparam int LANES    = 10;   // unique (i <= j) entry pairs
    localparam int ENTRIES  = NODES * NODES;

    localparam int CRDW     = 32;   // coordinate
    localparam int EW       = 33;   // edge vector component
    localparam int XW       = 67;   // cross product component
    localparam int CW       = 69;   // cofactor component
    localparam int DW       = 102;  // determinant
    localparam int GOPW     = 35;   // geometry multiplier operand
    localparam int LOW      = 35;   // low split of a cofactor
    localparam int MOPW     = 36;   // lane multiplier operand
    localparam int PW       = 140;  // cofactor dot product
    localparam int SIXW     = 104;  // six times |D|
    localparam int DENW     = 105;  // twelve times |D|
    localparam int NUMW     = 146;  // dividend
    localparam int QW       = 48;   // quotient / entry width
    localparam int REMW     = DENW + 1;
    localparam int DIV_BITS = 4;    // quotient bits per cycle

    localparam logic [3:0] GEOM_LAST = 4'd14;
    localparam logic [3:0] DOT_LAST  = 4'd14;
    localparam logic [3:0] DIV_LAST  = 4'd13;

    localparam logic signed [QW-1:0] ENTRY_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] ENTRY_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic signed [CRDW-1:0] node0_x;
        logic signed [CRDW-1:0] node0_y;
        logic signed [CRDW-1:0] node0_z;
        logic signed [CRDW-1:0] node1_x;
        logic signed [CRDW-1:0] node1_y;
        logic signed [CRDW-1:0] node1_z;
        logic signed [CRDW-1:0] node2_x;
        logic signed [CRDW-1:0] node2_y;
        logic signed [CRDW-1:0] node2_z;
        logic signed [CRDW-1:0] node3_x;
        logic signed [CRDW-1:0] node3_y;
        logic signed [CRDW-1:0] node3_z;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]             row_index;
        logic [1:0]             col_index;
        logic signed [QW-1:0]   entry_value;
        logic                   singular_flag;
        logic                   saturated_flag;
        logic                   last_entry;
    } t_out_beat;

    // Lockstep control for all lanes
    typedef struct packed {
        logic       dot_load;
        logic       mul_en;
        logic [3:0] mul_step;
        logic       acc_en;
        logic [1:0] acc_part;
        logic       dot_fin;
        logic       div_load;
        logic       div_init;
        logic       div_iter;
    } t_lane_ctrl;

    typedef struct packed {
        logic signed [QW-1:0] value;
        logic                 sat;
    } t_lane_res;

    // Row node of a lane
    function automatic logic [1:0] lane_row(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
            4'd4, 4'd5, 4'd6:       r = 2'd1;
            4'd7, 4'd8:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    // Column node of a lane
    function automatic logic [1:0] lane_col(input logic [3:0] k);
        logic [1:0] c;
        unique case (k)
            4'd0:             c = 2'd0;
            4'd1, 4'd4:       c = 2'd1;
            4'd2, 4'd5, 4'd7: c = 2'd2;
            default:          c = 2'd3;
        endcase
        return c;
    endfunction

    // Lane that holds row-major entry idx (matrix is symmetric)
    function automatic logic [3:0] pair_lane(input logic [3:0] idx);
        logic [3:0] k;
        unique case (idx)
            4'd0:         k = 4'd0;
            4'd1, 4'd4:   k = 4'd1;
            4'd2, 4'd8:   k = 4'd2;
            4'd3, 4'd12:  k = 4'd3;
            4'd5:         k = 4'd4;
            4'd6, 4'd9:   k = 4'd5;
            4'd7, 4'd13:  k = 4'd6;
            4'd10:        k = 4'd7;
            4'd11, 4'd14: k = 4'd8;
            default:      k = 4'd9;
        endcase
        return k;
    endfunction

endpackage

[sv/tls_in_if.sv]
// ----------------------------------------------------------------------------
// tls_in_if
// Element channel: one beat carries the twelve vertex coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tls_in_if import tls_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/tls_out_if.sv]
// ----------------------------------------------------------------------------
// tls_out_if
// Entry channel: one beat carries one stiffness entry with its flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tls_out_if import tls_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/tls_geom.sv]
// ----------------------------------------------------------------------------
// tls_geom
// Edge vectors, cofactor vectors c0..c3 and |D| of one element, computed
// in a sequence of steps on two shared multipliers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tls_geom import tls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_in_beat              i_beat,
    input  logic                  i_take,
    output logic                  o_busy,
    output logic                  o_done,
    output logic signed [CW-1:0]  o_cof [NODES][3],
    output logic [DW-1:0]         o_absd,
    output logic                  o_sing
);

    typedef struct packed {
        logic [1:0] ci;
        logic [1:0] m;
    } t_xsel;

    // Cross product step -> (vector, component)
    function automatic t_xsel xsel(input logic [3:0] s);
        t_xsel x;
        unique case (s)
            4'd0:    x = '{2'd0, 2'd0};
            4'd1:    x = '{2'd0, 2'd1};
            4'd2:    x = '{2'd0, 2'd2};
            4'd3:    x = '{2'd1, 2'd0};
            4'd4:    x = '{2'd1, 2'd1};
            4'd5:    x = '{2'd1, 2'd2};
            4'd6:    x = '{2'd2, 2'd0};
            4'd7:    x = '{2'd2, 2'd1};
            default: x = '{2'd2, 2'd2};
        endcase
        return x;
    endfunction

    function automatic logic [1:0] nx3(input logic [1:0] m);
        logic [1:0] r;
        unique case (m)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    logic signed [CRDW-1:0]   w_p [NODES][3];
    logic signed [EW-1:0]     r_e [3][3];
    logic signed [CW-1:0]     r_cof [NODES][3];
    logic signed [DW-1:0]     r_d;
    logic [DW-1:0]            r_absd;
    logic                     r_sing;
    logic                     r_busy;
    logic [3:0]               r_step;
    logic signed [2*GOPW-1:0] r_p0;
    logic signed [2*GOPW-1:0] r_p1;

    t_xsel                    w_x;
    t_xsel                    w_wbx;
    logic [1:0]               w_ea;
    logic [1:0]               w_eb;
    logic [1:0]               w_m1;
    logic [1:0]               w_m2;
    logic [1:0]               w_da;
    logic [3:0]               w_wb;
    logic signed [GOPW-1:0]   w_ma0;
    logic signed [GOPW-1:0]   w_mb0;
    logic signed [GOPW-1:0]   w_ma1;
    logic signed [GOPW-1:0]   w_mb1;
    logic signed [2*GOPW-1:0] w_xdiff;
    logic signed [DW-1:0]     w_dsum;

    // Unpack the coordinates
    assign w_p[0][0] = i_beat.node0_x;
    assign w_p[0][1] = i_beat.node0_y;
    assign w_p[0][2] = i_beat.node0_z;
    assign w_p[1][0] = i_beat.node1_x;
    assign w_p[1][1] = i_beat.node1_y;
    assign w_p[1][2] = i_beat.node1_z;
    assign w_p[2][0] = i_beat.node2_x;
    assign w_p[2][1] = i_beat.node2_y;
    assign w_p[2][2] = i_beat.node2_z;
    assign w_p[3][0] = i_beat.node3_x;
    assign w_p[3][1] = i_beat.node3_y;
    assign w_p[3][2] = i_beat.node3_z;

    // Select multiplier operands for this step
    always_comb begin
        w_x  = xsel(r_step);
        w_ea = (w_x.ci == 2'd0) ? 2'd1 : ((w_x.ci == 2'd1) ? 2'd2 : 2'd0);
        w_eb = (w_x.ci == 2'd0) ? 2'd2 : ((w_x.ci == 2'd1) ? 2'd0 : 2'd1);
        w_m1 = nx3(w_x.m);
        w_m2 = nx3(w_m1);
        w_da = 2'(r_step - 4'd9);
        if (r_step < 4'd9) begin
            w_ma0 = GOPW'(r_e[w_ea][w_m1]);
            w_mb0 = GOPW'(r_e[w_eb][w_m2]);
            w_ma1 = GOPW'(r_e[w_ea][w_m2]);
            w_mb1 = GOPW'(r_e[w_eb][w_m1]);
        end else begin
            w_ma0 = GOPW'(r_e[0][w_da]);
            w_mb0 = $signed({1'b0, r_cof[1][w_da][33:0]});
            w_ma1 = GOPW'(r_e[0][w_da]);
            w_mb1 = GOPW'($signed(r_cof[1][w_da][XW-1:34]));
        end
    end

    assign w_wb    = r_step - 4'd1;
    assign w_wbx   = xsel(w_wb);
    assign w_xdiff = r_p0 - r_p1;
    assign w_dsum  = r_d + DW'(r_p0) + (DW'(r_p1) <<< 34);

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (i_take) begin
            r_busy <= 1'b0;
        end else if (r_busy && r_step != GEOM_LAST) begin
            r_step <= r_step + 4'd1;
        end
    end

    // Datapath: products, cofactors, determinant
    always_ff @(posedge i_clk) begin
        r_p0 <= w_ma0 * w_mb0;
        r_p1 <= w_ma1 * w_mb1;
        if (i_load) begin
            r_d <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int a = 0; a < 3; a++) begin
                    r_e[i][a] <= EW'(w_p[i+1][a]) - EW'(w_p[0][a]);
                end
            end
        end else if (r_busy) begin
            if (r_step >= 4'd1 && r_step <= 4'd9) begin
                r_cof[w_wbx.ci + 2'd1][w_wbx.m] <= CW'($signed(w_xdiff[XW-1:0]));
            end
            if (r_step >= 4'd10 && r_step <= 4'd12) begin
                r_d <= w_dsum;
            end
            if (r_step == 4'd13) begin
                for (int a = 0; a < 3; a++) begin
                    r_cof[0][a] <= -(r_cof[1][a] + r_cof[2][a] + r_cof[3][a]);
                end
                r_absd <= r_d[DW-1] ? DW'(-r_d) : DW'(r_d);
                r_sing <= (r_d == '0);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_step == GEOM_LAST);
    assign o_cof  = r_cof;
    assign o_absd = r_absd;
    assign o_sing = r_sing;

endmodule

[sv/tls_lane.sv]
// ----------------------------------------------------------------------------
// tls_lane
// One entry lane: cofactor dot product on one split multiplier, then a
// radix-16 restoring divide by 12|D| with rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tls_lane import tls_pkg::*; (
    input  logic                 i_clk,
    input  t_lane_ctrl           i_ctrl,
    input  logic signed [CW-1:0] i_ci [3],
    input  logic signed [CW-1:0] i_cj [3],
    input  logic [SIXW-1:0]      i_sixd,
    input  logic [DENW-1:0]      i_den,
    output t_lane_res            o_res
);

    logic signed [CW-1:0]     r_ci [3];
    logic signed [CW-1:0]     r_cj [3];
    logic signed [2*MOPW-1:0] r_prod;
    logic signed [PW-1:0]     r_acc;
    logic [PW-1:0]            r_mag;
    logic                     r_neg;
    logic                     r_dneg;
    logic [NUMW-1:0]          r_num;
    logic [REMW-1:0]          r_rem;
    logic [QW-1:0]            r_nsh;
    logic [QW-1:0]            r_q;
    logic                     r_big;

    logic [1:0]               w_a;
    logic signed [MOPW-1:0]   w_opi;
    logic signed [MOPW-1:0]   w_opj;
    logic signed [PW-1:0]     w_term;
    logic [REMW-1:0]          w_rem;
    logic [QW-1:0]            w_nsh;
    logic [QW-1:0]            w_q;
    logic [REMW-1:0]          w_top;
    logic                     w_big47;
    logic                     w_exact;

    // Pick halves of the cofactor components for this partial product
    assign w_a   = i_ctrl.mul_step[3:2];
    assign w_opi = i_ctrl.mul_step[1] ? MOPW'($signed(r_ci[w_a][CW-1:LOW]))
                                      : $signed({1'b0, r_ci[w_a][LOW-1:0]});
    assign w_opj = i_ctrl.mul_step[0] ? MOPW'($signed(r_cj[w_a][CW-1:LOW]))
                                      : $signed({1'b0, r_cj[w_a][LOW-1:0]});

    // Align the registered partial product
    always_comb begin
        case (i_ctrl.acc_part) inside
            2'd0:       w_term = PW'(r_prod);
            2'd1, 2'd2: w_term = PW'(r_prod) <<< LOW;
            default:    w_term = PW'(r_prod) <<< (2 * LOW);
        endcase
    end

    // Four restoring divide steps
    always_comb begin
        w_rem = r_rem;
        w_nsh = r_nsh;
        w_q   = r_q;
        for (int k = 0; k < DIV_BITS; k++) begin
            w_rem = {w_rem[REMW-2:0], w_nsh[QW-1]};
            w_nsh = {w_nsh[QW-2:0], 1'b0};
            if (w_rem >= REMW'(i_den)) begin
                w_rem = w_rem - REMW'(i_den);
                w_q   = {w_q[QW-2:0], 1'b1};
            end else begin
                w_q   = {w_q[QW-2:0], 1'b0};
            end
        end
    end

    assign w_top = REMW'(r_num[NUMW-1:QW]);

    // Dot product and divide registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.dot_load) begin
            r_ci  <= i_ci;
            r_cj  <= i_cj;
            r_acc <= '0;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_opi * w_opj;
        end
        if (i_ctrl.acc_en) begin
            r_acc <= r_acc + w_term;
        end
        if (i_ctrl.dot_fin) begin
            r_neg <= r_acc[PW-1];
            r_mag <= r_acc[PW-1] ? PW'(-r_acc) : PW'(r_acc);
        end
        if (i_ctrl.div_load) begin
            r_num  <= NUMW'({r_mag, 5'b0}) + NUMW'(i_sixd);
            r_dneg <= r_neg;
        end
        if (i_ctrl.div_init) begin
            r_rem <= w_top;
            r_big <= (w_top >= REMW'(i_den));
            r_nsh <= r_num[QW-1:0];
            r_q   <= '0;
        end
        if (i_ctrl.div_iter) begin
            r_rem <= w_rem;
            r_nsh <= w_nsh;
            r_q   <= w_q;
        end
    end

    // Sign, saturation
    assign w_big47 = r_big || r_q[QW-1];
    assign w_exact = !r_big && (r_q == ENTRY_MIN);

    always_comb begin
        if (!r_dneg) begin
            o_res.value = w_big47 ? ENTRY_MAX : $signed(r_q);
            o_res.sat   = w_big47;
        end else if (w_big47 && !w_exact) begin
            o_res.value = ENTRY_MIN;
            o_res.sat   = 1'b1;
        end else begin
            o_res.value = $signed(-r_q);
            o_res.sat   = 1'b0;
        end
    end

endmodule

[sv/tls_merge.sv]
// ----------------------------------------------------------------------------
// tls_merge
// Collects the ten lane results of one element and sends the sixteen
// entries in row-major order on the entry channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tls_merge import tls_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_lane_res  i_res [LANES],
    input  logic       i_sing,
    output logic       o_free,
    tls_out_if.source  o_entry
);

    t_lane_res  r_res [LANES];
    logic       r_sing;
    logic [3:0] r_idx;
    logic       r_active;

    logic       w_acc;
    logic       w_last;
    t_lane_res  w_sel;

    assign w_acc  = r_active && o_entry.ready;
    assign w_last = (r_idx == 4'(ENTRIES - 1));
    assign o_free = !r_active || (w_acc && w_last);

    // Beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (w_acc) begin
                r_idx <= w_last ? 4'd0 : r_idx + 4'd1;
                if (w_last) begin
                    r_active <= 1'b0;
                end
            end
            if (i_load) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end
        end
    end

    // Hold the element's results
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res  <= i_res;
            r_sing <= i_sing;
        end
    end

    assign w_sel = r_res[pair_lane(r_idx)];

    // Drive the beat
    assign o_entry.valid                  = r_active;
    assign o_entry.payload.row_index      = r_idx[3:2];
    assign o_entry.payload.col_index      = r_idx[1:0];
    assign o_entry.payload.entry_value    = r_sing ? '0 : w_sel.value;
    assign o_entry.payload.singular_flag  = r_sing;
    assign o_entry.payload.saturated_flag = !r_sing && w_sel.sat;
    assign o_entry.payload.last_entry     = w_last;

endmodule

[sv/tet4_laplace_stiffness_top.sv]
// ----------------------------------------------------------------------------
// tet4_laplace_stiffness_top
// Laplace element stiffness of a linear tetrahedron: twelve Q11.20
// coordinates in, sixteen Q23.24 entries V * (grad Li . grad Lj) out.
//
// Use:
//   i_elem  : one beat per element, the four vertices as x, y, z.
//   o_entry : sixteen beats per element, row-major, last_entry on the
//             sixteenth; singular_flag with zero entries when the volume is
//             zero, saturated_flag on an entry clipped to the Q23.24 range.
//   Four stages run on consecutive elements at once: geometry (cofactors
//   and determinant on two multipliers), ten entry lanes doing the dot
//   products and a 4-bit-per-cycle divide, then the output stage that
//   sends one beat a cycle while o_entry is ready.
//   A new element can enter before the last one has left the output stage;
//   i_elem.ready stays low while the geometry stage holds an element.
//   A stall on o_entry holds the current beat; the stages behind it fill
//   and then i_elem.ready drops. Nothing is lost.
//   Reset clears all stage control; no element is in flight afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tet4_laplace_stiffness_top import tls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tls_in_if.sink    i_elem,
    tls_out_if.source o_entry
);

    logic                 w_geom_busy;
    logic                 w_geom_done;
    logic signed [CW-1:0] w_cof [NODES][3];
    logic [DW-1:0]        w_absd;
    logic                 w_geom_sing;
    logic                 w_in_acc;

    logic                 r_dot_busy;
    logic [3:0]           r_dot_cnt;
    logic                 r_dot_sing;
    logic [SIXW-1:0]      r_dot_sixd;
    logic [DENW-1:0]      r_dot_den;
    logic                 w_dot_start;
    logic                 w_dot_done;

    logic                 r_div_busy;
    logic [3:0]           r_div_cnt;
    logic                 r_div_sing;
    logic [DENW-1:0]      r_div_den;
    logic                 w_div_start;
    logic                 w_div_done;

    logic                 w_mrg_free;
    logic                 w_mrg_load;
    t_lane_ctrl           w_ctrl;
    t_lane_res            w_res [LANES];

    assign i_elem.ready = !w_geom_busy;
    assign w_in_acc     = i_elem.valid && i_elem.ready;

    tls_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_acc),
        .i_beat  (i_elem.payload),
        .i_take  (w_dot_start),
        .o_busy  (w_geom_busy),
        .o_done  (w_geom_done),
        .o_cof   (w_cof),
        .o_absd  (w_absd),
        .o_sing  (w_geom_sing)
    );

    // Stage handoffs
    assign w_dot_start = w_geom_done && !r_dot_busy;
    assign w_dot_done  = r_dot_busy && (r_dot_cnt == DOT_LAST);
    assign w_div_start = w_dot_done && !r_div_busy;
    assign w_div_done  = r_div_busy && (r_div_cnt == DIV_LAST);
    assign w_mrg_load  = w_div_done && w_mrg_free;

    // Dot stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_busy <= 1'b0;
            r_dot_cnt  <= '0;
        end else if (w_dot_start) begin
            r_dot_busy <= 1'b1;
            r_dot_cnt  <= '0;
        end else if (w_div_start) begin
            r_dot_busy <= 1'b0;
        end else if (r_dot_busy && r_dot_cnt != DOT_LAST) begin
            r_dot_cnt <= r_dot_cnt + 4'd1;
        end
    end

    // Divide stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (w_div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (w_mrg_load) begin
            r_div_busy <= 1'b0;
        end else if (r_div_busy && r_div_cnt != DIV_LAST) begin
            r_div_cnt <= r_div_cnt + 4'd1;
        end
    end

    // Scale |D| and carry the singular flag along the stages
    always_ff @(posedge i_clk) begin
        if (w_dot_start) begin
            r_dot_sixd <= SIXW'({w_absd, 2'b0}) + SIXW'({w_absd, 1'b0});
            r_dot_den  <= DENW'({w_absd, 3'b0}) + DENW'({w_absd, 2'b0});
            r_dot_sing <= w_geom_sing;
        end
        if (w_div_start) begin
            r_div_den  <= r_dot_den;
            r_div_sing <= r_dot_sing;
        end
    end

    // Lockstep lane control
    always_comb begin
        w_ctrl.dot_load = w_dot_start;
        w_ctrl.mul_en   = r_dot_busy && (r_dot_cnt <= 4'd11);
        w_ctrl.mul_step = r_dot_cnt;
        w_ctrl.acc_en   = r_dot_busy && (r_dot_cnt >= 4'd1) && (r_dot_cnt <= 4'd12);
        w_ctrl.acc_part = 2'(r_dot_cnt - 4'd1);
        w_ctrl.dot_fin  = r_dot_busy && (r_dot_cnt == 4'd13);
        w_ctrl.div_load = w_div_start;
        w_ctrl.div_init = r_div_busy && (r_div_cnt == 4'd0);
        w_ctrl.div_iter = r_div_busy && (r_div_cnt >= 4'd1) && (r_div_cnt <= 4'd12);
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        tls_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_ci   (w_cof[lane_row(4'(k))]),
            .i_cj   (w_cof[lane_col(4'(k))]),
            .i_sixd (r_dot_sixd),
            .i_den  (r_div_den),
            .o_res  (w_res[k])
        );
    end

    tls_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_mrg_load),
        .i_res   (w_res),
        .i_sing  (r_div_sing),
        .o_free  (w_mrg_free),
        .o_entry (o_entry)
    );

    // Checks
    `ASSERT_PROP(a_accept_holds_geom, i_clk, i_rst_n, (i_elem.valid && i_elem.ready) |=> w_geom_busy)
    `ASSERT_PROP(a_singular_zero, i_clk, i_rst_n, (o_entry.valid && o_entry.payload.singular_flag) |-> (o_entry.payload.entry_value == '0))
    `ASSERT_NEVER(a_singular_not_sat, i_clk, i_rst_n, o_entry.valid && o_entry.payload.singular_flag && o_entry.payload.saturated_flag)
    `ASSERT_PROP(a_drain_idle, i_clk, i_rst_n, (o_entry.valid && o_entry.ready && o_entry.payload.last_entry && !w_div_done) |=> !o_entry.valid)

endmodule

[dv/tb_tet4_laplace_stiffness_top.sv]
// ----------------------------------------------------------------------------
// tb_tet4_laplace_stiffness_top
// Self-checking bench for the tetrahedron stiffness block: a directed table
// of elements, then random elements, with random idling on both channels.
// Each accepted element is predicted in wide integer arithmetic into its
// sixteen entries, which are compared field by field with the entry beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tet4_laplace_stiffness_top;
    import tls_pkg::*;

    typedef logic signed [255:0] t_wide;

    localparam int RANDOM_ELEMS = 360;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;

    tls_in_if  elem_if ();
    tls_out_if entry_if ();

    tet4_laplace_stiffness_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_if),
        .o_entry (entry_if)
    );

    t_in_beat  elem_queue[$];
    bit        flat_queue[$];     // 1: element known to have zero volume
    t_out_beat entry_expect[$];
    int        mismatches;
    int        accepted_elems;
    int        stall_cycles;
    bit        calm;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cross product of edge vectors a and b
    function automatic void cross3(input t_wide a[3], input t_wide b[3],
                                   output t_wide r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Work out the sixteen stiffness entries of one element
    function automatic void predict_entries(input t_in_beat elem, input bit flat);
        t_wide     crd[4][3];
        t_wide     edg[3][3];
        t_wide     cof[4][3];
        t_wide     det, absd, dd, num, den, quo;
        t_out_beat o;
        bit        neg;
        for (int n = 0; n < 4; n++)
            for (int a = 0; a < 3; a++)
                crd[n][a] = t_wide'($signed(elem[383 - 32 * (3 * n + a) -: 32]));
        for (int n = 0; n < 3; n++)
            for (int a = 0; a < 3; a++)
                edg[n][a] = crd[n + 1][a] - crd[0][a];
        cross3(edg[1], edg[2], cof[1]);
        cross3(edg[2], edg[0], cof[2]);
        cross3(edg[0], edg[1], cof[3]);
        for (int a = 0; a < 3; a++)
            cof[0][a] = -(cof[1][a] + cof[2][a] + cof[3][a]);
        det  = edg[0][0] * cof[1][0] + edg[0][1] * cof[1][1] + edg[0][2] * cof[1][2];
        absd = (det < 0) ? -det : det;
        den  = absd * 12;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                o = '0;
                o.row_index  = 2'(i);
                o.col_index  = 2'(j);
                o.last_entry = (i == 3 && j == 3);
                if (flat || det == 0) begin
                    o.singular_flag = 1'b1;
                end else begin
                    dd  = cof[i][0] * cof[j][0] + cof[i][1] * cof[j][1]
                        + cof[i][2] * cof[j][2];
                    neg = dd < 0;
                    num = ((neg ? -dd : dd) <<< 5) + absd * 6;
                    quo = num / den;
                    if (!neg && quo >= (t_wide'(1) <<< 47)) begin
                        o.entry_value    = ENTRY_MAX;
                        o.saturated_flag = 1'b1;
                    end else if (neg && quo > (t_wide'(1) <<< 47)) begin
                        o.entry_value    = ENTRY_MIN;
                        o.saturated_flag = 1'b1;
                    end else begin
                        o.entry_value = neg ? QW'(-quo) : QW'(quo);
                    end
                end
                entry_expect.push_back(o);
            end
        end
    endfunction

    function automatic t_in_beat make_elem(
        input int x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3);
        return {x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3};
    endfunction

    // Random element: mostly modest well-shaped ones, some full range,
    // some flat, some slivers
    function automatic t_in_beat rand_elem();
        int        c[12];
        int        base, span, pick;
        int        kind;
        kind = $urandom_range(99);
        base = $urandom_range(32'h0FFF_FFFF) - 32'h0800_0000;
        span = 1 << $urandom_range(24, 2);
        for (int k = 0; k < 12; k++) c[k] = base + $signed($urandom_range(2 * span) - span);
        if (kind >= 60 && kind < 78) begin
            for (int k = 0; k < 12; k++) c[k] = $urandom;
        end else if (kind >= 78 && kind < 88) begin
            pick = $urandom_range(2);
            if ($urandom_range(1)) begin
                // repeated vertex
                for (int a = 0; a < 3; a++) c[3 * (pick + 1) + a] = c[a];
            end else begin
                // all four vertices on one coordinate plane
                for (int n = 1; n < 4; n++) c[3 * n + pick] = c[pick];
            end
        end else if (kind >= 88) begin
            // sliver: wide in two axes, one to three units thick in the third
            for (int k = 0; k < 12; k++) c[k] = 0;
            c[3]  = $urandom_range(32'h7FFF_FFFF, 32'h0100_0000);
            c[7]  = $urandom_range(32'h7FFF_FFFF, 32'h0100_0000);
            c[11] = $urandom_range(3, 1);
            if ($urandom_range(1)) c[3] = -c[3];
        end
        return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
    endfunction

    // Element channel: hold a beat until taken, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_if.valid   <= 1'b0;
            elem_if.payload <= '0;
        end else begin
            if (elem_if.valid && elem_if.ready) begin
                predict_entries(elem_if.payload, flat_queue[0]);
                void'(elem_queue.pop_front());
                void'(flat_queue.pop_front());
                accepted_elems <= accepted_elems + 1;
            end
            if (elem_if.valid && !elem_if.ready) begin
                elem_if.valid <= 1'b1;
            end else if (elem_queue.size() > 0
                         && (calm || $urandom_range(99) >= 7)) begin
                elem_if.valid   <= 1'b1;
                elem_if.payload <= elem_queue[0];
            end else begin
                elem_if.valid <= 1'b0;
            end
        end
    end

    // Entry channel: random stalls, compare each beat with the oldest entry
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (!i_rst_n) begin
            entry_if.ready <= 1'b0;
        end else begin
            entry_if.ready <= calm || $urandom_range(99) >= 7;
            if (entry_if.valid && entry_if.ready) begin
                if (entry_expect.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected entry beat %p", entry_if.payload);
                end else begin
                    exp_beat = entry_expect.pop_front();
                    if (entry_if.payload.row_index      !== exp_beat.row_index
                     || entry_if.payload.col_index      !== exp_beat.col_index
                     || entry_if.payload.entry_value    !== exp_beat.entry_value
                     || entry_if.payload.singular_flag  !== exp_beat.singular_flag
                     || entry_if.payload.saturated_flag !== exp_beat.saturated_flag
                     || entry_if.payload.last_entry     !== exp_beat.last_entry) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("entry mismatch: expected %p, got %p",
                                     exp_beat, entry_if.payload);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (elem_if.valid && elem_if.ready)
            || (entry_if.valid && entry_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Long stretch without idling on either side
    always @(posedge i_clk) calm <= accepted_elems >= 150 && accepted_elems < 230;

    initial begin
        localparam int MAXC = 32'h7FFF_FFFF;
        localparam int MINC = 32'h8000_0000;
        localparam int ONE  = 1 << 20;
        t_in_beat dir_elem[$];
        bit       dir_flat[$];
        mismatches     = 0;
        accepted_elems = 0;
        calm           = 1'b0;

        // Directed table; flat rows carry their known result (all zero)
        dir_elem = '{
            make_elem(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            make_elem(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                      MAXC, MAXC, MAXC),
            make_elem(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
                      MINC, MINC, MINC),
            make_elem(0, 0, 5, ONE, 0, 5, 0, ONE, 5, ONE, ONE, 5),
            make_elem(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 7, 7, 7),
            make_elem(MINC, 0, 0, MAXC, 0, 0, 0, 0, 0, 12, 0, 0),
            make_elem(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
            make_elem(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE),
            make_elem(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1),
            make_elem(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC,
                      MINC, MINC, MAXC),
            make_elem(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC,
                      MAXC, MAXC, MINC),
            make_elem(0, 0, 0, MAXC, 0, 0, 0, MAXC, 0, 0, 0, 1),
            make_elem(0, 0, 0, MINC, 0, 0, 0, MAXC, 0, 0, 0, 1),
            make_elem(0, 0, 0, MAXC, 1, 0, 1, MAXC, 0, 0, 0, 1),
            make_elem(-ONE, -ONE, -ONE, 3 * ONE, ONE, -ONE, ONE, 2 * ONE, 0,
                      -2 * ONE, ONE, 4 * ONE),
            make_elem(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333,
                      32'hCCCC_CCCC, 32'h0000_FFFF, 32'hFFFF_0000, 32'h7F00_00FF)
        };
        dir_flat = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        foreach (dir_elem[k]) begin
            elem_queue.push_back(dir_elem[k]);
            flat_queue.push_back(dir_flat[k]);
        end
        for (int k = 0; k < RANDOM_ELEMS; k++) begin
            elem_queue.push_back(rand_elem());
            flat_queue.push_back(1'b0);
        end

        // Reset
        i_rst_n          = 1'b0;
        elem_if.valid    = 1'b0;
        elem_if.payload  = '0;
        entry_if.ready   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain
        while (elem_queue.size() != 0 || entry_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && entry_expect.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/tls_pkg.sv
sv/tls_in_if.sv
sv/tls_out_if.sv
sv/tls_geom.sv
sv/tls_lane.sv
sv/tls_merge.sv
sv/tet4_laplace_stiffness_top.sv
dv/tb_tet4_laplace_stiffness_top.sv
